// ===== rtl/bab_pkg.sv =====
// ---------------------------------------------------------------------------
// bab_pkg
// Shared types, widths and register codes of the background autocrop block.
// ---------------------------------------------------------------------------
package bab_pkg;

    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CHAN_W     = 8;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [POS_W-1:0]  crop_x;
        logic [POS_W-1:0]  crop_y;
        logic [SIZE_W-1:0] crop_w;
        logic [SIZE_W-1:0] crop_h;
        logic              whole_frame;
        logic              all_background;
    } t_result;

    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] reg_v,
                                                   input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] v;
        v = reg_v;
        if (reg_v == '0) begin
            v = CFG_W'(1);
        end else if (reg_v > lim) begin
            v = lim;
        end
        return v;
    endfunction

endpackage

// ===== rtl/bab_in_stage.sv =====
// ---------------------------------------------------------------------------
// bab_in_stage
// Input register that holds one pixel until the tracker consumes it.
// ---------------------------------------------------------------------------
module bab_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bab_pkg::t_pixel i_pixel,
    input  logic            i_adv,
    output logic            o_ready,
    output logic            o_valid,
    output bab_pkg::t_pixel o_pixel
);

    logic            r_valid;
    logic            n_valid;
    bab_pkg::t_pixel r_pixel;

    assign o_ready = !r_valid || i_adv;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel <= i_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_adv) |=> (r_valid && $stable(r_pixel)))
        else $error("Held pixel was lost or changed while the tracker stalled.");

endmodule

// ===== rtl/bab_tracker.sv =====
// ---------------------------------------------------------------------------
// bab_tracker
// Frame size registers, raster counters, border check and bounding box.
// ---------------------------------------------------------------------------
module bab_tracker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bab_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bab_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_step,
    input  bab_pkg::t_pixel                i_pixel,
    output logic                           o_done,
    output bab_pkg::t_result               o_result
);

    localparam int EFF_MAX = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int CW      = $clog2(EFF_MAX);
    localparam int SW      = CW + 1;
    localparam logic [bab_pkg::CFG_W-1:0] LIM = bab_pkg::CFG_W'(EFF_MAX);

    logic [bab_pkg::CFG_W-1:0] r_frame_width;
    logic [bab_pkg::CFG_W-1:0] r_frame_height;
    logic [23:0]               r_bg;
    logic [CW-1:0]             r_col;
    logic [CW-1:0]             r_row;
    logic                      r_border;
    logic                      r_found;
    logic [CW-1:0]             r_min_col;
    logic [CW-1:0]             r_max_col;
    logic [CW-1:0]             r_min_row;
    logic [CW-1:0]             r_max_row;

    logic [23:0]               n_bg;
    logic [CW-1:0]             n_col;
    logic [CW-1:0]             n_row;
    logic                      n_border;
    logic                      n_found;
    logic [CW-1:0]             n_min_col;
    logic [CW-1:0]             n_max_col;
    logic [CW-1:0]             n_min_row;
    logic [CW-1:0]             n_max_row;

    logic [bab_pkg::CFG_W-1:0] w_eff;
    logic [bab_pkg::CFG_W-1:0] h_eff;
    logic [23:0]               pix;
    logic                      first;
    logic                      diff;
    logic                      last_col;
    logic                      last_row;
    logic [SW-1:0]             span_w;
    logic [SW-1:0]             span_h;

    assign w_eff    = bab_pkg::eff_size(r_frame_width, LIM);
    assign h_eff    = bab_pkg::eff_size(r_frame_height, LIM);
    assign pix      = i_pixel;
    assign first    = (r_col == '0) && (r_row == '0);
    assign n_bg     = first ? pix : r_bg;
    assign diff     = pix != n_bg;
    assign last_col = bab_pkg::CFG_W'(r_col) >= (w_eff - bab_pkg::CFG_W'(1));
    assign last_row = bab_pkg::CFG_W'(r_row) >= (h_eff - bab_pkg::CFG_W'(1));
    assign o_done   = last_col && last_row;

    always_comb begin
        n_border  = r_border;
        n_found   = r_found;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        if (diff) begin
            if ((r_col == '0) || (r_row == '0) || last_col || last_row) begin
                n_border = 1'b1;
            end
            n_found = 1'b1;
            if (r_col < r_min_col) n_min_col = r_col;
            if (r_col > r_max_col) n_max_col = r_col;
            if (r_row < r_min_row) n_min_row = r_row;
            if (r_row > r_max_row) n_max_row = r_row;
        end
        n_col = r_col;
        n_row = r_row;
        if (!last_col) begin
            n_col = r_col + CW'(1);
        end else if (!last_row) begin
            n_col = '0;
            n_row = r_row + CW'(1);
        end
    end

    assign span_w = SW'(n_max_col) - SW'(n_min_col) + SW'(1);
    assign span_h = SW'(n_max_row) - SW'(n_min_row) + SW'(1);

    always_comb begin
        o_result = '0;
        if (n_border) begin
            o_result.crop_w      = bab_pkg::SIZE_W'(w_eff);
            o_result.crop_h      = bab_pkg::SIZE_W'(h_eff);
            o_result.whole_frame = 1'b1;
        end else if (!n_found) begin
            o_result.all_background = 1'b1;
        end else begin
            o_result.crop_x = bab_pkg::POS_W'(n_min_col);
            o_result.crop_y = bab_pkg::POS_W'(n_min_row);
            o_result.crop_w = bab_pkg::SIZE_W'(span_w);
            o_result.crop_h = bab_pkg::SIZE_W'(span_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bab_pkg::FRAME_WIDTH_RESET;
            r_frame_height <= bab_pkg::FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bab_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bab_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg      <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_border  <= 1'b0;
            r_found   <= 1'b0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
        end else if (i_step) begin
            r_bg <= n_bg;
            if (o_done) begin
                r_col     <= '0;
                r_row     <= '0;
                r_border  <= 1'b0;
                r_found   <= 1'b0;
                r_min_col <= '1;
                r_max_col <= '0;
                r_min_row <= '1;
                r_max_row <= '0;
            end else begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_border  <= n_border;
                r_found   <= n_found;
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
            end
        end
    end

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_done) |=> (r_col == '0 && r_row == '0 && !r_border && !r_found))
        else $error("Frame state was not cleared after the last pixel.");

    a_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_min_col <= r_max_col && r_min_row <= r_max_row))
        else $error("Bounding box corners are out of order.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found |-> (!r_border && r_min_col == '1 && r_max_col == '0))
        else $error("Bounding box moved without a differing pixel.");

endmodule

// ===== rtl/bab_out_stage.sv =====
// ---------------------------------------------------------------------------
// bab_out_stage
// Result register that holds one crop window until the consumer takes it.
// ---------------------------------------------------------------------------
module bab_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bab_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output bab_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    bab_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/background_autocrop_bbox.sv =====
// Path: the last pixel of a frame is held in the input register until the tracker steps on it,
// and the crop result is then loaded into the result register, which raises o_valid.
// Throughput: one pixel per cycle, set by the single tracker stage between the input
// register and the result register; only a frame's last pixel waits for an untaken result.
// Reset: synchronous, active low; clears the frame state and sets the frame size
// registers to 640 by 480.
// ---------------------------------------------------------------------------
// background_autocrop_bbox
// Finds the crop window of a raster frame against its first-pixel background.
// ---------------------------------------------------------------------------
module background_autocrop_bbox #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bab_pkg::CHAN_W-1:0]    i_red,
    input  logic [bab_pkg::CHAN_W-1:0]    i_green,
    input  logic [bab_pkg::CHAN_W-1:0]    i_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bab_pkg::POS_W-1:0]     o_crop_x,
    output logic [bab_pkg::POS_W-1:0]     o_crop_y,
    output logic [bab_pkg::SIZE_W-1:0]    o_crop_w,
    output logic [bab_pkg::SIZE_W-1:0]    o_crop_h,
    output logic                          o_whole_frame,
    output logic                          o_all_background,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bab_pkg::CFG_W-1:0]     i_cfg_data
);

    bab_pkg::t_pixel  in_pixel;
    bab_pkg::t_pixel  st_pixel;
    bab_pkg::t_result trk_result;
    bab_pkg::t_result out_result;
    logic             st_valid;
    logic             out_free;
    logic             adv;
    logic             step;
    logic             done;

    assign in_pixel.red   = i_red;
    assign in_pixel.green = i_green;
    assign in_pixel.blue  = i_blue;
    assign adv            = !done || out_free;
    assign step           = st_valid && adv;
    assign o_cfg_ready    = 1'b1;

    bab_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pixel (in_pixel),
        .i_adv   (adv),
        .o_ready (o_ready),
        .o_valid (st_valid),
        .o_pixel (st_pixel)
    );

    bab_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_trk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_pixel     (st_pixel),
        .o_done      (done),
        .o_result    (trk_result)
    );

    bab_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && done),
        .i_result (trk_result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_crop_x         = out_result.crop_x;
    assign o_crop_y         = out_result.crop_y;
    assign o_crop_w         = out_result.crop_w;
    assign o_crop_h         = out_result.crop_h;
    assign o_whole_frame    = out_result.whole_frame;
    assign o_all_background = out_result.all_background;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the background autocrop block. Raster frames of
// small and extreme sizes are streamed through the pixel channel. Frame sizes
// change between frames and within them. Every crop result is checked field
// by field against a transaction-level model of the crop tracker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = 4096;
    localparam int DRAIN        = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 750;

    typedef enum int {FILL_PLAIN, FILL_BLOB, FILL_BORDER, FILL_NOISE} t_fill;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_ready;
    logic [bab_pkg::CHAN_W-1:0]    i_red       = '0;
    logic [bab_pkg::CHAN_W-1:0]    i_green     = '0;
    logic [bab_pkg::CHAN_W-1:0]    i_blue      = '0;
    logic                          o_valid;
    logic                          i_ready     = 1'b0;
    logic [bab_pkg::POS_W-1:0]     o_crop_x;
    logic [bab_pkg::POS_W-1:0]     o_crop_y;
    logic [bab_pkg::SIZE_W-1:0]    o_crop_w;
    logic [bab_pkg::SIZE_W-1:0]    o_crop_h;
    logic                          o_whole_frame;
    logic                          o_all_background;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [bab_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bab_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    logic [bab_pkg::CFG_W-1:0] width_reg  = bab_pkg::FRAME_WIDTH_RESET;
    logic [bab_pkg::CFG_W-1:0] height_reg = bab_pkg::FRAME_HEIGHT_RESET;
    logic [23:0]               bg_color   = '0;
    int                        col_cnt;
    int                        row_cnt;
    int                        min_col;
    int                        max_col;
    int                        min_row;
    int                        max_row;
    bit                        border_hit;
    bit                        any_hit;

    bab_pkg::t_pixel  pixel_q[$];
    bab_pkg::t_result crop_q[$];
    int               pushed         = 0;
    int               accepted       = 0;
    int               errors         = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;

    background_autocrop_bbox #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_crop_x         (o_crop_x),
        .o_crop_y         (o_crop_y),
        .o_crop_w         (o_crop_w),
        .o_crop_h         (o_crop_h),
        .o_whole_frame    (o_whole_frame),
        .o_all_background (o_all_background),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int usable_size(input logic [bab_pkg::CFG_W-1:0] r);
        if (r == '0) begin
            return 1;
        end
        if (r > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(r);
    endfunction

    task automatic restart_frame();
        col_cnt    = 0;
        row_cnt    = 0;
        border_hit = 1'b0;
        any_hit    = 1'b0;
        min_col    = MAX_DIM - 1;
        max_col    = 0;
        min_row    = MAX_DIM - 1;
        max_row    = 0;
    endtask

    task automatic track_pixel(input bab_pkg::t_pixel px);
        int               w;
        int               h;
        logic [23:0]      color;
        bit               last_col;
        bit               last_row;
        bab_pkg::t_result res;
        w        = usable_size(width_reg);
        h        = usable_size(height_reg);
        color    = px;
        last_col = col_cnt >= w - 1;
        last_row = row_cnt >= h - 1;
        if (col_cnt == 0 && row_cnt == 0) begin
            bg_color = color;
        end
        if (color != bg_color) begin
            if (col_cnt == 0 || row_cnt == 0 || last_col || last_row) begin
                border_hit = 1'b1;
            end
            any_hit = 1'b1;
            if (col_cnt < min_col) min_col = col_cnt;
            if (col_cnt > max_col) max_col = col_cnt;
            if (row_cnt < min_row) min_row = row_cnt;
            if (row_cnt > max_row) max_row = row_cnt;
        end
        if (!last_col) begin
            col_cnt++;
        end else if (!last_row) begin
            col_cnt = 0;
            row_cnt++;
        end else begin
            res = '0;
            if (border_hit) begin
                res.crop_w      = bab_pkg::SIZE_W'(w);
                res.crop_h      = bab_pkg::SIZE_W'(h);
                res.whole_frame = 1'b1;
            end else if (!any_hit) begin
                res.all_background = 1'b1;
            end else begin
                res.crop_x = bab_pkg::POS_W'(min_col);
                res.crop_y = bab_pkg::POS_W'(min_row);
                res.crop_w = bab_pkg::SIZE_W'(max_col - min_col + 1);
                res.crop_h = bab_pkg::SIZE_W'(max_row - min_row + 1);
            end
            crop_q = {crop_q, res};
            restart_frame();
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                track_pixel({i_red, i_green, i_blue});
                accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    {i_red, i_green, i_blue} <= pixel_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        bab_pkg::t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (crop_q.size() == 0) begin
                    report_mismatch("crop result with no completed frame pending");
                end else begin
                    want = crop_q.pop_front();
                    compare_field("crop_x", 16'(o_crop_x), 16'(want.crop_x));
                    compare_field("crop_y", 16'(o_crop_y), 16'(want.crop_y));
                    compare_field("crop_w", 16'(o_crop_w), 16'(want.crop_w));
                    compare_field("crop_h", 16'(o_crop_h), 16'(want.crop_h));
                    compare_field("whole_frame", 16'(o_whole_frame),
                                  16'(want.whole_frame));
                    compare_field("all_background", 16'(o_all_background),
                                  16'(want.all_background));
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    task automatic push_pixel(input logic [23:0] c);
        pixel_q = {pixel_q, bab_pkg::t_pixel'(c)};
        pushed++;
    endtask

    task automatic wait_for_idle();
        while (accepted != pushed || crop_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bab_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bab_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        if (idx == bab_pkg::REG_FRAME_WIDTH) begin
            width_reg = value;
        end else begin
            height_reg = value;
        end
    endtask

    function automatic logic [23:0] pick_color();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return 24'h000000;
        end
        if (r == 1) begin
            return 24'hFFFFFF;
        end
        return 24'($urandom);
    endfunction

    function automatic logic [23:0] vary_color(input logic [23:0] c);
        logic [23:0] m;
        if ($urandom_range(3) == 0) begin
            return c ^ (24'd1 << $urandom_range(23));
        end
        m = 24'($urandom);
        if (m == '0) begin
            m = 24'd1;
        end
        return c ^ m;
    endfunction

    function automatic logic [bab_pkg::CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return '0;
        end
        if (r < 16) begin
            return bab_pkg::CFG_W'(1);
        end
        if (r < 20) begin
            return bab_pkg::CFG_W'($urandom_range(8191, 4096));
        end
        return bab_pkg::CFG_W'($urandom_range(8, 2));
    endfunction

    task automatic queue_pixels(input int count);
        int          w;
        int          h;
        int          x;
        int          y;
        bit          rim;
        logic [23:0] bg;
        t_fill       fill;
        w    = usable_size(width_reg);
        h    = usable_size(height_reg);
        x    = col_cnt;
        y    = row_cnt;
        bg   = bg_color;
        fill = t_fill'($urandom_range(3));
        repeat (count) begin
            if (x == 0 && y == 0) begin
                bg   = pick_color();
                fill = t_fill'($urandom_range(3));
            end
            rim = (x == 0 || y == 0 || x >= w - 1 || y >= h - 1);
            case (fill)
                FILL_PLAIN: begin
                    push_pixel(bg);
                end
                FILL_BLOB: begin
                    push_pixel((!rim && $urandom_range(3) == 0) ? vary_color(bg) : bg);
                end
                FILL_BORDER: begin
                    push_pixel(($urandom_range(7) == 0) ? vary_color(bg) : bg);
                end
                default: begin
                    push_pixel(24'($urandom));
                end
            endcase
            if (x < w - 1) begin
                x++;
            end else if (y < h - 1) begin
                x = 0;
                y++;
            end else begin
                x = 0;
                y = 0;
            end
        end
    endtask

    initial begin : stimulus
        int w;
        int h;
        int target;
        int phase;
        int count;
        restart_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes of 640 by 480: start a frame and break its top row.
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        wait_for_idle();

        // Zero sizes act as one, so the open frame closes on the next pixel.
        write_reg(bab_pkg::REG_FRAME_WIDTH, '0);
        write_reg(bab_pkg::REG_FRAME_HEIGHT, '0);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        wait_for_idle();

        // Oversized registers clamp to the maximum frame size.
        write_reg(bab_pkg::REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(bab_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        push_pixel(24'hA5A5A5);
        push_pixel(24'hA5A5A5);
        push_pixel(24'hA5A5A4);
        wait_for_idle();
        write_reg(bab_pkg::REG_FRAME_WIDTH, 13'd4096);
        write_reg(bab_pkg::REG_FRAME_HEIGHT, 13'd4096);
        push_pixel(24'hA5A5A5);
        push_pixel(24'hA5A5A5);
        wait_for_idle();

        // Shrinking below the current position ends the row and the frame.
        write_reg(bab_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(bab_pkg::REG_FRAME_HEIGHT, 13'd1);
        push_pixel(24'hA5A5A5);
        wait_for_idle();

        // A single interior pixel gives a one by one crop window.
        write_reg(bab_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(bab_pkg::REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++) begin
            push_pixel((i == 4) ? 24'h654321 : 24'h123456);
        end

        target = pushed + RANDOM_ITEMS;
        phase  = 0;
        while (pushed < target) begin
            wait_for_idle();
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            write_reg(bab_pkg::REG_FRAME_WIDTH, pick_size());
            write_reg(bab_pkg::REG_FRAME_HEIGHT, pick_size());
            w = usable_size(width_reg);
            h = usable_size(height_reg);
            if (w * h > 64) begin
                count = $urandom_range(12, 1);
            end else begin
                count = $urandom_range(3, 1) * w * h +
                        (($urandom_range(3) == 0) ? $urandom_range(w, 1) : 0);
            end
            if (count > target - pushed) begin
                count = target - pushed;
            end
            queue_pixels(count);
            phase++;
        end

        wait_for_idle();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
